// File: rtl/ssd_nearest_template_search_unit_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef SSD_NEAREST_TEMPLATE_SEARCH_UNIT_MACROS_SVH
`define SSD_NEAREST_TEMPLATE_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define SSDNTS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSDNTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssdnts_pkg.sv
package ssdnts_pkg;

    localparam int MAX_FRAMES   = 16;
    localparam int IMAGE_WIDTH  = 40;
    localparam int IMAGE_HEIGHT = 30;

    localparam int PIXELS      = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int STORE_DEPTH = MAX_FRAMES * PIXELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(PIXELS + 1);
    localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);
    localparam int FRAME_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    localparam int PIX_W  = 16;
    localparam int ID_W   = 16;
    localparam int SUM_W  = 48;
    localparam int DIFF_W = PIX_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [PIX_W-1:0] pixel_value;
        logic [ID_W-1:0]         frame_id;
        logic                    last_pixel;
    } pixel_t;

    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   best_id;
        logic [SUM_W-1:0]  best_distance;
    } result_t;

endpackage

// File: rtl/ssdnts_ram.sv
module ssdnts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/ssd_nearest_template_search_unit.sv
// nearest stored template by sum of squared differences. a store beat (operation 0) writes
// one pixel of the frame being stored into the frame memory; its last_pixel beat closes the
// frame and latches its id. a query beat (operation 1) runs one shared
// subtract-square-accumulate unit over all stored frames, one frame per cycle through a
// three-stage pipe (memory read, square, saturating add); the rate is set by that single
// multiply-accumulate and the single read port of the frame memory. after the last query
// beat the finish state loads the result (smallest sum, earliest frame on ties) into the
// output register, and waits there only if an earlier result has not been taken. sums
// clear as they are consumed by the last beat.
module ssd_nearest_template_search_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  ssdnts_pkg::pixel_t  pixel,
    output logic                result_valid,
    input  logic                result_stall,
    output ssdnts_pkg::result_t result
);
    import ssdnts_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [COUNT_W-1:0] frame_count_reg, frame_count_next;
    logic [POS_W-1:0]   store_pos_reg, store_pos_next;
    logic [ADDR_W-1:0]  store_base_reg, store_base_next;
    logic [POS_W-1:0]   query_pos_reg, query_pos_next;

    logic signed [PIX_W-1:0] q_reg, q_next;
    logic last_reg, last_next;
    logic add_en_reg, add_en_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [FRAME_W-1:0] s1_idx_reg, s1_idx_next;
    logic               s2_valid_reg, s2_valid_next;
    logic [FRAME_W-1:0] s2_idx_reg, s2_idx_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    logic [SUM_W-1:0]   sums_reg [MAX_FRAMES];
    logic [ID_W-1:0]    ids_reg [MAX_FRAMES];
    logic [SUM_W-1:0]   best_reg, best_next;
    logic [FRAME_W-1:0] best_idx_reg, best_idx_next;

    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic accept;
    logic id_we;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] square;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;

    ssdnts_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pixel_stall  = (state_reg != ST_IDLE);
    assign accept       = pixel_valid && !pixel_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // square stage works on the memory word that arrived this cycle
    assign diff   = DIFF_W'(q_reg) - DIFF_W'($signed(ram_rdata));
    assign square = diff * diff;

    // accumulate stage, saturating at the sum width
    assign sum_wide = {1'b0, sums_reg[s2_idx_reg]} + (SUM_W + 1)'(prod_reg);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        frame_count_next = frame_count_reg;
        store_pos_next   = store_pos_reg;
        store_base_next  = store_base_reg;
        query_pos_next   = query_pos_reg;
        q_next           = q_reg;
        last_next        = last_reg;
        add_en_next      = add_en_reg;
        k_next           = k_reg;
        addr_next        = addr_reg;
        s1_valid_next    = 1'b0;
        s1_idx_next      = s1_idx_reg;
        s2_valid_next    = s1_valid_reg;
        s2_idx_next      = s1_idx_reg;
        prod_next        = add_en_reg ? PROD_W'(unsigned'(square)) : '0;
        best_next        = best_reg;
        best_idx_next    = best_idx_reg;
        result_next      = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        id_we            = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = store_base_reg + ADDR_W'(store_pos_reg);
        ram_wdata        = pixel.pixel_value;
        ram_re           = 1'b0;
        ram_raddr        = addr_reg;

        if (s2_valid_reg && (s2_idx_reg == '0 || sum_sat < best_reg))
        begin
            best_next     = sum_sat;
            best_idx_next = s2_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pixel.operation == OP_STORE)
                    begin
                        ram_we = (frame_count_reg < COUNT_W'(MAX_FRAMES))
                                 && (store_pos_reg < POS_W'(PIXELS));
                        if (store_pos_reg < POS_W'(PIXELS))
                        begin
                            store_pos_next = store_pos_reg + 1'b1;
                        end
                        if (pixel.last_pixel)
                        begin
                            store_pos_next = '0;
                            if (frame_count_reg < COUNT_W'(MAX_FRAMES))
                            begin
                                id_we            = 1'b1;
                                frame_count_next = frame_count_reg + 1'b1;
                                store_base_next  = store_base_reg + ADDR_W'(PIXELS);
                            end
                        end
                    end
                    else
                    begin
                        q_next      = pixel.pixel_value;
                        last_next   = pixel.last_pixel;
                        add_en_next = (query_pos_reg < POS_W'(PIXELS));
                        addr_next   = ADDR_W'(query_pos_reg);
                        k_next      = '0;
                        if (pixel.last_pixel)
                        begin
                            query_pos_next = '0;
                        end
                        else if (query_pos_reg < POS_W'(PIXELS))
                        begin
                            query_pos_next = query_pos_reg + 1'b1;
                        end
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (k_reg < frame_count_reg)
                begin
                    ram_re        = 1'b1;
                    addr_next     = addr_reg + ADDR_W'(PIXELS);
                    k_next        = k_reg + 1'b1;
                    s1_valid_next = 1'b1;
                    s1_idx_next   = k_reg[FRAME_W-1:0];
                end
                else if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    result_next.found = (frame_count_reg != '0);
                    result_next.best_id = (frame_count_reg != '0) ? ids_reg[best_idx_reg] : '0;
                    result_next.best_distance = (frame_count_reg != '0) ? best_reg : '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_count_reg  <= '0;
            store_pos_reg    <= '0;
            store_base_reg   <= '0;
            query_pos_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            frame_count_reg  <= frame_count_next;
            store_pos_reg    <= store_pos_next;
            store_base_reg   <= store_base_next;
            query_pos_reg    <= query_pos_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
            // the last beat consumes each sum and leaves it cleared
            if (s2_valid_reg)
            begin
                sums_reg[s2_idx_reg] <= last_reg ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        last_reg     <= last_next;
        add_en_reg   <= add_en_next;
        k_reg        <= k_next;
        addr_reg     <= addr_next;
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        prod_reg     <= prod_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        result_reg   <= result_next;
        if (id_we)
        begin
            ids_reg[frame_count_reg[FRAME_W-1:0]] <= pixel.frame_id;
        end
    end

    `include "ssd_nearest_template_search_unit_macros.svh"

    `SSDNTS_ASSERT_IMPLIES(a_stage_in_range, s2_valid_reg, COUNT_W'(s2_idx_reg) < frame_count_reg, "accumulate stage beyond stored frames")
    `SSDNTS_ASSERT_IMPLIES(a_empty_result, result_valid_reg && !result_reg.found, result_reg.best_id == '0 && result_reg.best_distance == '0, "empty store result not zero")
    `SSDNTS_ASSERT_NEXT(a_finish_loads, state_reg == ST_FINISH && (!result_valid_reg || !result_stall), result_valid_reg && state_reg == ST_IDLE, "finished query did not load result")
    `SSDNTS_ASSERT_IMPLIES(a_query_pos_bounded, 1'b1, query_pos_reg <= POS_W'(PIXELS), "query position past image end")

endmodule
